@@ rtl/lhal_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lhal_pkg: shared types and constants of the luma histogram auto-level block
// Sizes, register indexes, mode codes, sequencer states and divider bundles.
// ----------------------------------------------------------------------------
package lhal_pkg;

  localparam int HIST_BINS       = 256;
  localparam int BIN_W           = $clog2(HIST_BINS);
  localparam int COUNT_WIDTH_DEF = 48;
  localparam int SUM_W           = 64;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 80;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_FRAC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FIX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd5;

  // divider: numerator up to 131072*255+255, divisor 2*d up to 510
  localparam int DIV_NUM_W = 25;
  localparam int DIV_DEN_W = 9;

  localparam logic [23:0] QPF_UNITY   = 24'd65536;
  localparam logic [23:0] QPF_MAX     = 24'hFF_FFFF;
  localparam logic [15:0] SCALE_UNITY = 16'd1024;
  localparam logic [15:0] SCALE_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_SAMPLE    = 2'd0,
    MODE_FRAME_END = 2'd1,
    MODE_QP        = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INC,
    S_SEED,
    S_SUM,
    S_CLIP0,
    S_CLIP1,
    S_BLK,
    S_WHT,
    S_LVL,
    S_DIV_S,
    S_DIV_F,
    S_RES,
    S_QP
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ rtl/lhal_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lhal_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lhal_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/lhal_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lhal_div: restoring unsigned divider
// One quotient bit per cycle; done pulses one cycle with the quotient held.
// ----------------------------------------------------------------------------
module lhal_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lhal_pkg::div_req_t  req_i,
  output lhal_pkg::div_rsp_t  rsp_o
);
  import lhal_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] rem_q, den_q, rem_nxt;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W+1:0] diff;
  logic                 fits;

  assign rem_sh  = {rem_q, quo_q[DIV_NUM_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, den_q};
  assign fits    = ~diff[DIV_DEN_W+1];
  assign rem_nxt = fits ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
      rem_q <= rem_nxt;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.den != '0)
    else $error("divider started with zero divisor");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finished run");

endmodule
`default_nettype wire

@@ rtl/luma_histogram_auto_level_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// luma_histogram_auto_level_top: luma histogram with auto black/white levels
// Counts luma samples in a 256-bin histogram held in RAM, finds clip-based
// black and white points at frame end, derives gain, offset and a quantizer
// factor, and corrects quantizer values with that factor.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid/tready           tuser: mode; tdata: sample, qp_in
// m_axis    out        tvalid/tready           tdata: levels, gain, factor, qp_out
// cfg       in         cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
// Sequencing: a sample transaction reads the RAM, then writes back the
// saturated count. A quantizer transaction is answered from S_QP. A frame end
// walks the RAM one bin per cycle: every bin for the sum, then the black and
// white walks to the clip point or the end, plus up to two divider runs.
// Reset: the bin valid flags clear at once, so no clearing pass is needed.
// Stalls: results wait in an output register; the sequencer holds in its
// result state and takes no new transaction until that register frees.
// ----------------------------------------------------------------------------
module luma_histogram_auto_level_top #(
  parameter int COUNT_WIDTH = lhal_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave side
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] sample, [14:8] qp_in, [15] zero
  input  logic [lhal_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [lhal_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  // master side
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] black_point, [15:8] white_point, [31:16] scale_q10,
  // [40:32] level_offset, [64:41] qp_factor, [65] degenerate,
  // [73:66] qp_out, [79:74] zero
  output logic [lhal_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [lhal_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lhal_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import lhal_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [BIN_W-1:0]       BIN_LAST  = BIN_W'(HIST_BINS - 1);

  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  qp_out;
    logic        degenerate;
    logic [23:0] qp_factor;
    logic [8:0]  level_offset;
    logic [15:0] scale_q10;
    logic [7:0]  white_point;
    logic [7:0]  black_point;
  } out_t;

  // ---------------- configuration registers ----------------
  logic [15:0] cfg_clip_frac_q;
  logic [7:0]  cfg_min_y_q, cfg_max_y_q;
  logic        cfg_level_fix_q;
  logic [13:0] cfg_width_q, cfg_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_clip_frac_q <= 16'd655;
      cfg_min_y_q     <= 8'd16;
      cfg_max_y_q     <= 8'd234;
      cfg_level_fix_q <= 1'b0;
      cfg_width_q     <= 14'd720;
      cfg_height_q    <= 14'd576;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLIP_FRAC: cfg_clip_frac_q <= cfg_wdata_i;
        CFG_MIN_Y:     cfg_min_y_q     <= cfg_wdata_i[7:0];
        CFG_MAX_Y:     cfg_max_y_q     <= cfg_wdata_i[7:0];
        CFG_LEVEL_FIX: cfg_level_fix_q <= cfg_wdata_i[0];
        CFG_WIDTH:     cfg_width_q     <= cfg_wdata_i[13:0];
        CFG_HEIGHT:    cfg_height_q    <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  // ---------------- state ----------------
  state_e state_q, state_d;

  logic [BIN_W-1:0] idx_q, idx_d;
  logic [SUM_W-1:0] sum_q, sum_d, left_q, left_d, clip_q, clip_d;
  logic [47:0]      prod_lo_q, prod_lo_d;
  logic [7:0]       black_q, black_d, white_q, white_d;
  logic [15:0]      scale_q, scale_d;
  logic [23:0]      factor_q, factor_d;   // factor of the frame being computed
  logic [23:0]      qpf_q, qpf_d;         // factor in use for quantizer items
  logic             degen_q, degen_d;
  logic [6:0]       qp_q, qp_d;
  logic             first_done_q, first_done_d;

  // ---------------- histogram RAM with valid flags and forwarding ----------------
  logic                   mem_we;
  logic [COUNT_WIDTH-1:0] mem_wdata, ram_rdata, hist_rd;
  logic [HIST_BINS-1:0]   hist_vld_q;
  logic                   rd_vld_q, fwd_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;

  lhal_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (HIST_BINS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (mem_wdata),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  // a never-written bin reads as zero; a same-cycle write is forwarded
  assign hist_rd = fwd_q ? fwd_data_q : (rd_vld_q ? ram_rdata : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (mem_we) begin
        hist_vld_q[idx_q] <= 1'b1;
      end
      rd_vld_q <= hist_vld_q[idx_d];
      fwd_q    <= mem_we && (idx_q == idx_d);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= mem_wdata;
  end

  // ---------------- divider ----------------
  div_req_t div_req;
  div_rsp_t div_rsp;

  lhal_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------- datapath helpers ----------------
  mode_e in_mode;
  logic  in_acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = mode_e'(s_axis_tuser);

  // first-frame seed: w*h/64*15/256
  logic [27:0] wh;
  logic [21:0] wh_64;
  logic [25:0] wh_x15;
  logic [17:0] seed;
  assign wh     = 28'(cfg_width_q) * 28'(cfg_height_q);
  assign wh_64  = wh[27:6];
  assign wh_x15 = {wh_64, 4'b0000} - 26'(wh_64);
  assign seed   = wh_x15[25:8];  // below 2^18, never reaches a count limit

  // saturating sum and subtract against the bin just read
  logic [SUM_W:0]   sum_add, left_dif;
  logic [SUM_W-1:0] sum_sat, left_sub;
  logic             left_lt_clip;
  assign sum_add      = {1'b0, sum_q} + {1'b0, SUM_W'(hist_rd)};
  assign sum_sat      = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign left_dif     = {1'b0, left_q} - {1'b0, SUM_W'(hist_rd)};
  assign left_sub     = left_dif[SUM_W] ? '0 : left_dif[SUM_W-1:0];
  assign left_lt_clip = left_q < clip_q;

  // clip = floor(sum * fraction / 65536), in two 32x16 partial products
  logic [47:0] prod_hi;
  logic [79:0] clip_full;
  assign prod_hi   = 48'(sum_q[63:32]) * 48'(cfg_clip_frac_q);
  assign clip_full = {prod_hi, 32'd0} + 80'(prod_lo_q);

  // level math
  logic       deg, g_neg;
  logic [7:0] d_lvl, g_lvl;
  logic [DIV_NUM_W-1:0] num_scale, num_factor;
  logic [DIV_DEN_W-1:0] den_lvl;
  assign deg        = (white_q <= black_q);
  assign g_neg      = (cfg_max_y_q < cfg_min_y_q);
  assign d_lvl      = white_q - black_q;
  assign g_lvl      = cfg_max_y_q - cfg_min_y_q;
  assign num_scale  = DIV_NUM_W'({g_lvl, 11'd0}) + DIV_NUM_W'(d_lvl);
  assign num_factor = DIV_NUM_W'({g_lvl, 17'd0}) + DIV_NUM_W'(d_lvl);
  assign den_lvl    = {d_lvl, 1'b0};

  logic [15:0] quo_scale;
  logic [23:0] quo_factor;
  assign quo_scale  = (div_rsp.quo[DIV_NUM_W-1:16] != '0) ? SCALE_MAX : div_rsp.quo[15:0];
  assign quo_factor = (div_rsp.quo[DIV_NUM_W-1:24] != '0) ? QPF_MAX : div_rsp.quo[23:0];

  // quantizer correction: (qp*factor + 0.5 in Q16) >> 16, saturated
  logic [30:0] qp_prod;
  logic [31:0] qp_rnd;
  logic [7:0]  qp_corr;
  assign qp_prod = 31'(qp_q) * 31'(qpf_q);
  assign qp_rnd  = 32'(qp_prod) + 32'd32768;
  assign qp_corr = (qp_rnd[31:24] != 8'd0) ? 8'hFF : qp_rnd[23:16];

  // ---------------- output register ----------------
  logic out_vld_q, out_free, out_load;
  out_t out_q, out_nxt;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_nxt;
    end
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_SAMPLE:    state_d = S_INC;
            MODE_FRAME_END: state_d = first_done_q ? S_SUM : S_SEED;
            MODE_QP:        state_d = S_QP;
            default:        state_d = S_IDLE;
          endcase
        end
      end
      S_INC:   state_d = S_IDLE;
      S_SEED:  state_d = S_SUM;
      S_SUM: begin
        if (idx_q == BIN_LAST) state_d = S_CLIP0;
      end
      S_CLIP0: state_d = S_CLIP1;
      S_CLIP1: state_d = S_BLK;
      S_BLK: begin
        if (left_lt_clip || idx_q == '0) state_d = S_WHT;
      end
      S_WHT: begin
        if (left_lt_clip || idx_q == BIN_LAST) state_d = S_LVL;
      end
      S_LVL:   state_d = (deg || g_neg) ? S_RES : S_DIV_S;
      S_DIV_S: begin
        if (div_rsp.done) state_d = cfg_level_fix_q ? S_DIV_F : S_RES;
      end
      S_DIV_F: begin
        if (div_rsp.done) state_d = S_RES;
      end
      S_RES, S_QP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- sequencer: datapath and outputs ----------------
  always_comb begin
    idx_d        = idx_q;
    sum_d        = sum_q;
    left_d       = left_q;
    clip_d       = clip_q;
    prod_lo_d    = prod_lo_q;
    black_d      = black_q;
    white_d      = white_q;
    scale_d      = scale_q;
    factor_d     = factor_q;
    qpf_d        = qpf_q;
    degen_d      = degen_q;
    qp_d         = qp_q;
    first_done_d = first_done_q;
    mem_we       = 1'b0;
    mem_wdata    = hist_rd;
    div_req      = '0;
    out_load     = 1'b0;
    out_nxt      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          // the RAM read goes out now, at the bin to update or at bin 0
          idx_d = (in_mode == MODE_SAMPLE) ? s_axis_tdata[7:0] : '0;
          sum_d = '0;
          qp_d  = s_axis_tdata[14:8];
        end
      end
      S_INC: begin
        mem_we    = 1'b1;
        mem_wdata = (hist_rd == COUNT_MAX) ? hist_rd : hist_rd + COUNT_WIDTH'(1);
      end
      S_SEED: begin
        mem_we       = 1'b1;
        mem_wdata    = COUNT_WIDTH'(seed);
        first_done_d = 1'b1;
      end
      S_SUM: begin
        sum_d = sum_sat;
        if (idx_q != BIN_LAST) idx_d = idx_q + BIN_W'(1);
      end
      S_CLIP0: begin
        prod_lo_d = 48'(sum_q[31:0]) * 48'(cfg_clip_frac_q);
      end
      S_CLIP1: begin
        clip_d = clip_full[79:16];
        left_d = sum_q;
        idx_d  = BIN_LAST;
      end
      S_BLK: begin
        if (left_lt_clip || idx_q == '0) begin
          black_d = idx_q;
          left_d  = sum_q;
          idx_d   = '0;
        end else begin
          left_d = left_sub;
          idx_d  = idx_q - BIN_W'(1);
        end
      end
      S_WHT: begin
        if (left_lt_clip) begin
          white_d = idx_q;
        end else begin
          left_d = left_sub;
          if (idx_q == BIN_LAST) begin
            white_d = BIN_LAST;   // walk ran off the top
          end else begin
            idx_d = idx_q + BIN_W'(1);
          end
        end
      end
      S_LVL: begin
        degen_d = deg;
        if (deg) begin
          scale_d  = SCALE_UNITY;
          factor_d = QPF_UNITY;
        end else if (g_neg) begin
          scale_d  = '0;
          factor_d = cfg_level_fix_q ? '0 : QPF_UNITY;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = num_scale;
          div_req.den   = den_lvl;
        end
      end
      S_DIV_S: begin
        if (div_rsp.done) begin
          scale_d = quo_scale;
          if (cfg_level_fix_q) begin
            div_req.start = 1'b1;
            div_req.num   = num_factor;
            div_req.den   = den_lvl;
          end else begin
            factor_d = QPF_UNITY;
          end
        end
      end
      S_DIV_F: begin
        if (div_rsp.done) factor_d = quo_factor;
      end
      S_RES: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_nxt.black_point  = black_q;
          out_nxt.white_point  = white_q;
          out_nxt.scale_q10    = scale_q;
          out_nxt.level_offset = {1'b0, black_q} - {1'b0, cfg_min_y_q};
          out_nxt.qp_factor    = factor_q;
          out_nxt.degenerate   = degen_q;
          qpf_d                = factor_q;
        end
      end
      S_QP: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_nxt.qp_factor = qpf_q;
          out_nxt.qp_out    = qp_corr;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      first_done_q <= 1'b0;
      qpf_q        <= QPF_UNITY;
    end else begin
      state_q      <= state_d;
      first_done_q <= first_done_d;
      qpf_q        <= qpf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    sum_q     <= sum_d;
    left_q    <= left_d;
    clip_q    <= clip_d;
    prod_lo_q <= prod_lo_d;
    black_q   <= black_d;
    white_q   <= white_d;
    scale_q   <= scale_d;
    factor_q  <= factor_d;
    degen_q   <= degen_d;
    qp_q      <= qp_d;
  end

  // ---------------- assertions ----------------
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten");

  a_seed_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d == S_SUM) |-> first_done_q)
    else $error("frame sum started without first-frame seed");

  a_degen_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && state_q == S_RES && out_nxt.degenerate) |->
      (out_nxt.scale_q10 == SCALE_UNITY && out_nxt.qp_factor == QPF_UNITY))
    else $error("degenerate levels without unity gain");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV_S || state_q == S_DIV_F))
    else $error("divider result arrived outside a divide state");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the luma histogram auto-level block
// Feeds sample, frame-end and quantizer transactions through the input stream
// with random gaps, and keeps its own histogram, levels and quantizer factor
// in step. Each output transaction is checked field by field against the
// oldest predicted one. Register settings change between idle phases.
// ----------------------------------------------------------------------------
module tb;
  import lhal_pkg::*;

  // mode code the block must ignore
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // register indexes past the end of the list, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam int                   COUNT_W  = COUNT_WIDTH_DEF;
  localparam logic [COUNT_W-1:0]   BIN_FULL = '1;
  localparam int                   GAP_MAX  = 17;
  // let any trailing frame-end work finish
  localparam int                   SETTLE_CYCLES = 900;
  // cycles with no transaction on either stream before the run is abandoned
  localparam int                   STALL_LIMIT = 5000;

  // output tdata layout, MSB first
  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  qp_out;
    logic        degenerate;
    logic [23:0] qp_factor;
    logic [8:0]  level_offset;
    logic [15:0] scale_q10;
    logic [7:0]  white_point;
    logic [7:0]  black_point;
  } levels_t;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] sample;
    logic [6:0] qp_in;
  } luma_item_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [7:0] sample, [14:8] qp_in, [15] zero
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;  // [1:0] mode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // see levels_t, black_point lowest
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;

  luma_histogram_auto_level_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Level predictor: histogram, seed flag, current factor and register copies
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0] bin_count [HIST_BINS];
  bit                 seed_done;
  logic [23:0]        qp_scale_q16;
  logic [15:0]        clip_frac;
  logic [7:0]         y_floor;
  logic [7:0]         y_ceil;
  bit                 level_fix;
  logic [13:0]        pic_w;
  logic [13:0]        pic_h;

  luma_item_t stim_items[$];       // waiting for the input stream
  levels_t    expected_levels[$];  // predicted output transactions, oldest first
  int         error_count = 0;

  // Applies one input transaction to the predicted state; returns 1 with the
  // predicted output when the transaction produces one.
  function automatic bit histogram_step(input luma_item_t it, output levels_t res);
    logic [63:0] total, clip_cnt, left, seed, acc, q;
    int          blk, wht, span, gain_rng;
    bit          has_res;
    has_res = 1'b0;
    res     = '0;
    case (it.mode)
      MODE_SAMPLE: begin
        if (bin_count[it.sample] != BIN_FULL)
          bin_count[it.sample] = bin_count[it.sample] + 1'b1;
      end
      MODE_FRAME_END: begin
        // first frame end after reset seeds bin 0 from the picture size
        if (!seed_done) begin
          seed = 64'(pic_w) * 64'(pic_h) / 64 * 15 / 256;
          bin_count[0] = (seed > 64'(BIN_FULL)) ? BIN_FULL : seed[COUNT_W-1:0];
          seed_done = 1'b1;
        end
        total = '0;
        for (int k = 0; k < HIST_BINS; k++) begin
          acc   = total + 64'(bin_count[k]);
          total = (acc < total) ? '1 : acc;
        end
        clip_cnt = (total >> 16) * 64'(clip_frac) +
                   (((total & 64'hFFFF) * 64'(clip_frac)) >> 16);
        // black point: walk down until what is left drops below the clip
        left = total;
        for (blk = 255; blk > 0; blk--) begin
          if (left < clip_cnt) break;
          left = (left > 64'(bin_count[blk])) ? left - 64'(bin_count[blk]) : '0;
        end
        // white point: walk up the same way, clamped to the top bin
        left = total;
        for (wht = 0; wht < HIST_BINS; wht++) begin
          if (left < clip_cnt) break;
          left = (left > 64'(bin_count[wht])) ? left - 64'(bin_count[wht]) : '0;
        end
        if (wht > 255) wht = 255;
        span     = wht - blk;
        gain_rng = int'(y_ceil) - int'(y_floor);
        if (span <= 0) begin
          res.degenerate = 1'b1;
          res.scale_q10  = SCALE_UNITY;
          qp_scale_q16   = QPF_UNITY;
        end else if (gain_rng < 0) begin
          // inverted output range: negative gain clips to zero
          res.scale_q10 = '0;
          qp_scale_q16  = level_fix ? '0 : QPF_UNITY;
        end else begin
          q = (64'(gain_rng) * 2048 + 64'(span)) / (64'(span) * 2);
          res.scale_q10 = (q > 64'(SCALE_MAX)) ? SCALE_MAX : q[15:0];
          if (level_fix) begin
            q = (64'(gain_rng) * 131072 + 64'(span)) / (64'(span) * 2);
            qp_scale_q16 = (q > 64'(QPF_MAX)) ? QPF_MAX : q[23:0];
          end else begin
            qp_scale_q16 = QPF_UNITY;
          end
        end
        res.black_point  = 8'(blk);
        res.white_point  = 8'(wht);
        res.level_offset = 9'(blk - int'(y_floor));
        res.qp_factor    = qp_scale_q16;
        has_res = 1'b1;
      end
      MODE_QP: begin
        q = (64'(it.qp_in) * 64'(qp_scale_q16) + 64'd32768) >> 16;
        res.qp_factor = qp_scale_q16;
        res.qp_out    = (q > 64'd255) ? 8'hFF : q[7:0];
        has_res = 1'b1;
      end
      default: ;  // unused mode: no effect
    endcase
    return has_res;
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] exp_v,
                                      input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: pops pending items, with random gaps between items and
  // quiet stretches where items go back to back.
  // --------------------------------------------------------------------------
  luma_item_t cur_item;
  int         tx_gap;
  bit         tx_quiet;

  always @(posedge clk_i or negedge rst_ni) begin : driver_proc
    levels_t predicted;
    int      gap;
    bit      take;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap        <= 0;
    end else begin
      take = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        // transaction accepted: advance the predictor
        if (histogram_step(cur_item, predicted))
          expected_levels.push_back(predicted);
        if ($urandom_range(0, 24) == 0) tx_quiet = ~tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap == 0 && stim_items.size() != 0) begin
          take = 1'b1;  // valid stays high, next item follows directly
        end else begin
          s_axis_tvalid <= 1'b0;
          tx_gap        <= (gap > 0) ? gap - 1 : 0;
        end
      end else if (!s_axis_tvalid) begin
        if (tx_gap > 0)
          tx_gap <= tx_gap - 1;
        else if (stim_items.size() != 0)
          take = 1'b1;
      end
      if (take) begin
        cur_item      = stim_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, cur_item.qp_in, cur_item.sample};
        s_axis_tuser  <= cur_item.mode;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: checks each transaction, then may hold ready low for random stall cycles
  // --------------------------------------------------------------------------
  int rx_stall;
  bit rx_quiet;

  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    levels_t seen;
    levels_t want;
    int      stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = levels_t'(m_axis_tdata);
        if (expected_levels.size() == 0) begin
          $error("output transaction with nothing predicted: tdata %h", m_axis_tdata);
          error_count++;
        end else begin
          want = expected_levels.pop_front();
          check_field("black_point",  want.black_point,  seen.black_point);
          check_field("white_point",  want.white_point,  seen.white_point);
          check_field("scale_q10",    want.scale_q10,    seen.scale_q10);
          check_field("level_offset", $signed(want.level_offset), $signed(seen.level_offset));
          check_field("qp_factor",    want.qp_factor,    seen.qp_factor);
          check_field("degenerate",   want.degenerate,   seen.degenerate);
          check_field("qp_out",       want.qp_out,       seen.qp_out);
        end
        if ($urandom_range(0, 24) == 0) rx_quiet = ~rx_quiet;
        stall = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          rx_stall      <= stall - 1;
        end
      end else if (!m_axis_tready) begin
        if (rx_stall > 0)
          rx_stall <= rx_stall - 1;
        else
          m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either stream ends the run
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Register write; the predictor copy changes with it. Only called while idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_CLIP_FRAC: clip_frac = val;
      CFG_MIN_Y:     y_floor   = val[7:0];
      CFG_MAX_Y:     y_ceil    = val[7:0];
      CFG_LEVEL_FIX: level_fix = val[0];
      CFG_WIDTH:     pic_w     = val[13:0];
      CFG_HEIGHT:    pic_h     = val[13:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void queue_item(input logic [1:0] mode, input logic [7:0] sample,
                                     input logic [6:0] qp_in);
    luma_item_t it;
    it.mode   = mode;
    it.sample = sample;
    it.qp_in  = qp_in;
    stim_items.push_back(it);
  endfunction

  // Wait until every item is sent and every result is back, then let any
  // work that produces no result (sample write-back) run out.
  task automatic wait_idle();
    while (stim_items.size() != 0 || s_axis_tvalid || expected_levels.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Mostly frame-shaped traffic: a burst of samples, often clustered around one level,
  // a frame end, then a few quantizer items. The rest is loose random items.
  task automatic random_traffic(input int n_items);
    int         made, burst_len, n_qp;
    logic [7:0] center, spread;
    logic [1:0] mode;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
        center    = 8'($urandom);
        case ($urandom_range(0, 3))
          0:       spread = 8'h00;
          1:       spread = 8'h03;
          2:       spread = 8'h1F;
          default: spread = 8'hFF;
        endcase
        repeat (burst_len) queue_item(MODE_SAMPLE, center ^ (8'($urandom) & spread), 7'($urandom));
        queue_item(MODE_FRAME_END, 8'($urandom), 7'($urandom));
        n_qp = $urandom_range(0, 3);
        repeat (n_qp) queue_item(MODE_QP, 8'($urandom), 7'($urandom));
        made += burst_len + 1 + n_qp;
      end else begin
        mode = 2'($urandom_range(0, 3));
        queue_item(mode, 8'($urandom), 7'($urandom));
        if (mode != MODE_UNUSED) made++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    for (int k = 0; k < HIST_BINS; k++) bin_count[k] = '0;
    seed_done    = 1'b0;
    qp_scale_q16 = QPF_UNITY;
    clip_frac    = 16'd655;
    y_floor      = 8'd16;
    y_ceil       = 8'd234;
    level_fix    = 1'b0;
    pic_w        = 14'd720;
    pic_h        = 14'd576;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // smallest legal width with a height that gives a one-count seed in bin 0;
    // spare indexes must leave everything unchanged
    write_reg(CFG_WIDTH, 16'd8);
    write_reg(CFG_HEIGHT, 16'd160);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h5A5A);
    @(negedge clk_i);

    // directed: extreme samples, unused mode, extreme quantizers at unity,
    // first frame end overwriting the sample counted in bin 0
    queue_item(MODE_SAMPLE,    8'd0,   7'($urandom));
    queue_item(MODE_SAMPLE,    8'd255, 7'($urandom));
    queue_item(MODE_UNUSED,    8'($urandom), 7'($urandom));
    queue_item(MODE_QP,        8'($urandom), 7'd0);
    queue_item(MODE_QP,        8'($urandom), 7'd127);
    queue_item(MODE_FRAME_END, 8'($urandom), 7'($urandom));
    queue_item(MODE_QP,        8'($urandom), 7'd127);
    queue_item(MODE_QP,        8'($urandom), 7'd1);
    wait_idle();

    // narrow peak at half clip: white just above black, gain saturates,
    // level fix pushes the corrected quantizer into saturation
    write_reg(CFG_CLIP_FRAC, 16'd32768);
    write_reg(CFG_MIN_Y, 16'd0);
    write_reg(CFG_MAX_Y, 16'd255);
    write_reg(CFG_LEVEL_FIX, 16'd1);
    @(negedge clk_i);
    repeat (6) queue_item(MODE_SAMPLE, 8'd100, 7'($urandom));
    queue_item(MODE_FRAME_END, 8'($urandom), 7'($urandom));
    queue_item(MODE_QP,        8'($urandom), 7'd127);
    queue_item(MODE_QP,        8'($urandom), 7'd1);
    wait_idle();

    // inverted output range gives zero gain and zero factor; one more top
    // sample then crosses the walks and makes the levels degenerate
    write_reg(CFG_CLIP_FRAC, 16'hFFFF);
    write_reg(CFG_MIN_Y, 16'd255);
    write_reg(CFG_MAX_Y, 16'd0);
    @(negedge clk_i);
    queue_item(MODE_FRAME_END, 8'($urandom), 7'($urandom));
    queue_item(MODE_QP,        8'($urandom), 7'd127);
    queue_item(MODE_SAMPLE,    8'd255, 7'($urandom));
    queue_item(MODE_FRAME_END, 8'($urandom), 7'($urandom));
    queue_item(MODE_QP,        8'($urandom), 7'd50);
    wait_idle();

    // random phase 1: no clipping, full output range, largest picture size
    write_reg(CFG_CLIP_FRAC, 16'd0);
    write_reg(CFG_MIN_Y, 16'd0);
    write_reg(CFG_MAX_Y, 16'd255);
    write_reg(CFG_WIDTH, 16'd8192);
    write_reg(CFG_HEIGHT, 16'd8192);
    @(negedge clk_i);
    random_traffic(100);
    wait_idle();

    // random phase 2: random clip, output range and level fix, range may be inverted
    write_reg(CFG_CLIP_FRAC, 16'($urandom));
    write_reg(CFG_MIN_Y, 16'($urandom_range(0, 255)));
    write_reg(CFG_MAX_Y, 16'($urandom_range(0, 255)));
    write_reg(CFG_LEVEL_FIX, 16'($urandom_range(0, 1)));
    write_reg(CFG_SPARE_A, 16'($urandom));
    @(negedge clk_i);
    random_traffic(100);
    wait_idle();

    // random phase 3: clip nearly everything, reset output range, no level fix
    write_reg(CFG_CLIP_FRAC, 16'hFFFF);
    write_reg(CFG_MIN_Y, 16'd16);
    write_reg(CFG_MAX_Y, 16'd234);
    write_reg(CFG_LEVEL_FIX, 16'd0);
    @(negedge clk_i);
    random_traffic(100);
    wait_idle();

    // random phase 4: default clip, wide random range, level fix on
    write_reg(CFG_CLIP_FRAC, 16'd655);
    write_reg(CFG_MIN_Y, 16'($urandom_range(0, 64)));
    write_reg(CFG_MAX_Y, 16'($urandom_range(192, 255)));
    write_reg(CFG_LEVEL_FIX, 16'd1);
    write_reg(CFG_WIDTH, 16'($urandom_range(8, 8192)));
    write_reg(CFG_HEIGHT, 16'($urandom_range(8, 8192)));
    write_reg(CFG_SPARE_B, 16'($urandom));
    @(negedge clk_i);
    random_traffic(100);
    wait_idle();

    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lhal_pkg.sv
rtl/lhal_ram.sv
rtl/lhal_div.sv
rtl/luma_histogram_auto_level_top.sv
tb/tb.sv
